// ===== src/gww_pkg.sv =====
// shared types, sizes and register codes of the greedy word wrapper
package gww_pkg;

  // sizing
  localparam int GEOMETRY_ENTRIES = 4;
  localparam int SIZE_BITS        = 16;
  localparam int INDEX_BITS       = 16;

  localparam int ENTRY_W  = 2;
  localparam int NUM_GEOM = 4;
  localparam int GEOM_W   = SIZE_BITS + ENTRY_W;
  localparam int CUR_W    = SIZE_BITS + 1;
  localparam int NEED_W   = SIZE_BITS + 2;
  localparam int SUM_W    = SIZE_BITS + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GEOM_W;

  localparam logic [GEOM_W-1:0]     GEOM_RESET = GEOM_W'(32'd65535);
  localparam logic [INDEX_BITS-1:0] INDEX_MAX  = {INDEX_BITS{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_GEOMETRY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILING_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_3     = 3'd5;

  // small queues of the front and back parts
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [ENTRY_W-1:0]                first_geometry;
    logic [SIZE_BITS-1:0]              trailing_space;
    logic [NUM_GEOM-1:0][GEOM_W-1:0]   geometry;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [SIZE_BITS-1:0] word_width;
    logic [CUR_W-1:0]     word_gap;
    logic [NEED_W-1:0]    need;
    logic                 final_word;
  } word_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] break_word_index;
    logic [ENTRY_W-1:0]    new_line_geometry;
  } res_t;

  // front to back handshake
  typedef struct packed {
    logic  valid;
    word_t word;
  } wq_t;

  // geometry entry lookup, out of range entries read entry 0
  function automatic logic [GEOM_W-1:0] entry_reg(
    input logic [NUM_GEOM-1:0][GEOM_W-1:0] geom,
    input logic [ENTRY_W-1:0]              e
  );
    logic [GEOM_W-1:0] r;
    if (int'(e) >= GEOMETRY_ENTRIES) r = geom[0];
    else                             r = geom[e];
    return r;
  endfunction

endpackage

// ===== src/gww_front.sv =====
// front part: accepts words, precomputes their room needs, queues them
module gww_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [gww_pkg::SIZE_BITS-1:0]   in_word_width,
  input  logic [gww_pkg::SIZE_BITS-1:0]   in_gap_width,
  input  logic                            in_final_word,
  input  logic [gww_pkg::SIZE_BITS-1:0]   trailing_space,
  output gww_pkg::wq_t                    wq,
  input  logic                            wq_pop
);
  import gww_pkg::*;

  word_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push, pop;
  word_t              cls;

  // classify: word plus gap, and the total room it needs on this line
  always_comb begin
    cls.word_width = in_word_width;
    cls.word_gap   = CUR_W'(in_word_width) + CUR_W'(in_gap_width);
    cls.need       = NEED_W'(cls.word_gap)
                   + (in_final_word ? NEED_W'(trailing_space) : NEED_W'(0));
    cls.final_word = in_final_word;
  end

  assign in_full = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push    = in_push && !in_full;
  assign pop     = wq_pop && (count_r != '0);

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr_r] <= cls;
  end

  assign wq.valid = (count_r != '0);
  assign wq.word  = entries[rd_ptr_r];

endmodule

// ===== src/gww_back.sv =====
// back part: line state, fit decision and result queue
module gww_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gww_pkg::cfg_t                    cfg,
  input  gww_pkg::wq_t                     wq,
  output logic                             wq_pop,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [gww_pkg::INDEX_BITS-1:0]   out_break_word_index,
  output logic [gww_pkg::ENTRY_W-1:0]      out_new_line_geometry
);
  import gww_pkg::*;

  logic [CUR_W-1:0]      cursor_r, cursor_nxt;
  logic [SIZE_BITS-1:0]  cur_width_r, cur_width_nxt;
  logic [ENTRY_W-1:0]    cur_entry_r, cur_entry_nxt;
  logic [INDEX_BITS-1:0] word_count_r, word_count_nxt;

  res_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  logic              res_full, fire, first, fits, res_push, res_pop;
  logic [SUM_W-1:0]  sum;
  logic [ENTRY_W-1:0] next_entry, first_entry;
  logic [GEOM_W-1:0] cur_geom, next_geom, first_geom;
  res_t              res;

  assign res_full = (count_r == Q_CNT_W'(Q_DEPTH));
  assign fire     = wq.valid && !res_full;
  assign wq_pop   = fire;

  // fit check: cursor plus all the room this word needs against the line
  assign first = (word_count_r == '0);
  assign sum   = SUM_W'(cursor_r) + SUM_W'(wq.word.need);
  assign fits  = (sum <= SUM_W'(cur_width_r));

  // geometry lookups for a new line and for a paragraph start
  assign first_entry = cfg.first_geometry;
  assign first_geom  = entry_reg(cfg.geometry, first_entry);
  assign cur_geom    = entry_reg(cfg.geometry, cur_entry_r);
  assign next_entry  = cur_geom[GEOM_W-1:SIZE_BITS];
  assign next_geom   = entry_reg(cfg.geometry, next_entry);

  assign res_push = fire && !first && !fits;
  assign res.break_word_index  = word_count_r;
  assign res.new_line_geometry = next_entry;

  // line state update
  always_comb begin
    cursor_nxt     = cursor_r;
    cur_width_nxt  = cur_width_r;
    cur_entry_nxt  = cur_entry_r;
    word_count_nxt = word_count_r;
    if (fire) begin
      if (first) begin
        cur_entry_nxt = first_entry;
        cur_width_nxt = first_geom[SIZE_BITS-1:0];
        cursor_nxt    = wq.word.word_gap;
      end else if (fits) begin
        cursor_nxt    = CUR_W'(cursor_r + wq.word.word_gap);
      end else begin
        cur_entry_nxt = next_entry;
        cur_width_nxt = next_geom[SIZE_BITS-1:0];
        cursor_nxt    = CUR_W'(wq.word.word_width);
      end
      if (word_count_r != INDEX_MAX) word_count_nxt = word_count_r + 1'b1;
      // paragraph done, back to the start
      if (wq.word.final_word) begin
        cursor_nxt     = '0;
        cur_width_nxt  = '0;
        cur_entry_nxt  = '0;
        word_count_nxt = '0;
      end
    end
  end

  // result queue pointers
  assign res_pop = out_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (res_push) wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (res_pop)  rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (res_push && !res_pop)      count_nxt = count_r + 1'b1;
    else if (res_pop && !res_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      cur_width_r  <= '0;
      cur_entry_r  <= '0;
      word_count_r <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      cursor_r     <= cursor_nxt;
      cur_width_r  <= cur_width_nxt;
      cur_entry_r  <= cur_entry_nxt;
      word_count_r <= word_count_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      count_r      <= count_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (res_push) entries[wr_ptr_r] <= res;
  end

  assign out_empty             = (count_r == '0);
  assign out_break_word_index  = entries[rd_ptr_r].break_word_index;
  assign out_new_line_geometry = entries[rd_ptr_r].new_line_geometry;

endmodule

// ===== src/greedy_word_wrap.sv =====
// greedy word wrapper top level: configuration registers, front and back parts
// a word is held in the front queue, then its breakpoint in the result queue
// throughput: one word per cycle while the result queue has room, set by the back part's cursor add and compare loop
// the front and back parts each hold a two-entry queue, so either side may stall alone
// reset (synchronous, rst_n low): line state cleared, both queues empty,
// registers back to their reset values; no clearing pass, ready the next cycle
module greedy_word_wrap (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [gww_pkg::SIZE_BITS-1:0]    in_word_width,
  input  logic [gww_pkg::SIZE_BITS-1:0]    in_gap_width,
  input  logic                             in_final_word,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [gww_pkg::INDEX_BITS-1:0]   out_break_word_index,
  output logic [gww_pkg::ENTRY_W-1:0]      out_new_line_geometry,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gww_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gww_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gww_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  wq_t  wq;
  logic wq_pop;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // register writes, unknown indexes dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_GEOMETRY: cfg_nxt.first_geometry = cfg_data[ENTRY_W-1:0];
        REG_TRAILING_SPACE: cfg_nxt.trailing_space = cfg_data[SIZE_BITS-1:0];
        REG_GEOMETRY_0:     cfg_nxt.geometry[0]    = cfg_data;
        REG_GEOMETRY_1:     cfg_nxt.geometry[1]    = cfg_data;
        REG_GEOMETRY_2:     cfg_nxt.geometry[2]    = cfg_data;
        REG_GEOMETRY_3:     cfg_nxt.geometry[3]    = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_geometry <= '0;
      cfg_r.trailing_space <= '0;
      cfg_r.geometry       <= {NUM_GEOM{GEOM_RESET}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gww_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_word_width  (in_word_width),
    .in_gap_width   (in_gap_width),
    .in_final_word  (in_final_word),
    .trailing_space (cfg_r.trailing_space),
    .wq             (wq),
    .wq_pop         (wq_pop)
  );

  gww_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .wq                    (wq),
    .wq_pop                (wq_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_break_word_index  (out_break_word_index),
    .out_new_line_geometry (out_new_line_geometry)
  );

  // after reset both queues are empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full && !wq.valid))
    else $error("queues not empty after reset");

  // back part only takes a word the front part holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wq_pop |-> wq.valid)
    else $error("back part took a word from an empty queue");

  // back part stalls only on a full result queue, so results must be waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (wq.valid && !wq_pop) |-> !out_empty)
    else $error("back part stalled with no result waiting");

  // input side full means the front queue holds a word for the back part
  a_full_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> wq.valid)
    else $error("input full while front queue empty");

endmodule
